FILE: sv/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants for the stream group reverser.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int VALUE_W        = 32;
  localparam int GROUP_SIZE_W   = 5;
  localparam int MAX_GROUP_DEF  = 16;
  localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RST = 5'd3;

  // Sequencer states: collecting a group, or reading it back out
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } sgr_state_t;

  // Buffer memory strobes from the sequencer
  typedef struct packed {
    logic we;     // write the accepted value
    logic re;     // issue one read
    logic rlast;  // the read being issued is the final result of a sequence
  } sgr_mem_ctl_t;

endpackage

FILE: sv/sgr_if.sv
// ----------------------------------------------------------------------------
// sgr_if
// Valid/ready channels for input values and reordered results.
// ----------------------------------------------------------------------------
interface sgr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sgr_pkg::VALUE_W-1:0]  value;
  logic                                last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface sgr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sgr_pkg::VALUE_W-1:0]  result_value;
  logic                                result_last;

  modport source (output valid, output result_value, output result_last, input ready);
  modport sink   (input valid, input result_value, input result_last, output ready);
endinterface

FILE: sv/sgr_seq.sv
// ----------------------------------------------------------------------------
// sgr_seq
// Fill/drain sequencer: tracks the group fill level and walks read addresses.
// ----------------------------------------------------------------------------
module sgr_seq #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_last,
  output logic                                in_ready,
  input  logic [sgr_pkg::GROUP_SIZE_W-1:0]    group_size,
  input  logic                                rd_free,
  output sgr_pkg::sgr_mem_ctl_t               ctl,
  output logic [$clog2(MAX_GROUP)-1:0]        waddr,
  output logic [$clog2(MAX_GROUP)-1:0]        raddr
);
  import sgr_pkg::*;

  localparam int AW = $clog2(MAX_GROUP);
  localparam int FW = $clog2(MAX_GROUP + 1);

  sgr_state_t    state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          rev_r, rev_nxt;
  logic          seql_r, seql_nxt;

  logic [FW-1:0] k_eff;
  logic [FW-1:0] n;
  logic          accept;
  logic          issue;
  logic          full;

  // effective group size: 0 and 1 act as 1, large values clamp
  always_comb begin
    if (group_size <= GROUP_SIZE_W'(1)) begin
      k_eff = FW'(1);
    end else if (32'(group_size) > 32'(MAX_GROUP)) begin
      k_eff = FW'(MAX_GROUP);
    end else begin
      k_eff = FW'(group_size);
    end
  end

  assign accept = in_valid && in_ready;
  assign n      = fill_r + FW'(1);
  assign full   = (n >= k_eff);
  assign issue  = (state_r == ST_DRAIN) && rd_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (accept && (full || in_last)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (issue && cnt_r == FW'(1)) state_nxt = ST_FILL;
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_FILL);
    ctl.we    = accept;
    ctl.re    = issue;
    ctl.rlast = seql_r && (cnt_r == FW'(1));
    waddr     = fill_r[AW-1:0];
    raddr     = idx_r;
  end

  // counters and drain walk
  always_comb begin
    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    rev_nxt  = rev_r;
    seql_nxt = seql_r;
    if (accept) begin
      if (full || in_last) begin
        fill_nxt = '0;
        cnt_nxt  = n;
        rev_nxt  = full;
        idx_nxt  = full ? fill_r[AW-1:0] : '0;
        seql_nxt = in_last;
      end else begin
        fill_nxt = n;
      end
    end else if (issue) begin
      cnt_nxt = cnt_r - FW'(1);
      idx_nxt = rev_r ? idx_r - AW'(1) : idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    rev_r  <= rev_nxt;
    seql_r <= seql_nxt;
  end

endmodule

FILE: sv/sgr_mem.sv
// ----------------------------------------------------------------------------
// sgr_mem
// Group buffer memory with registered read and the result output register.
// ----------------------------------------------------------------------------
module sgr_mem #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sgr_pkg::sgr_mem_ctl_t               ctl,
  input  logic [$clog2(MAX_GROUP)-1:0]        waddr,
  input  logic signed [sgr_pkg::VALUE_W-1:0]  wdata,
  input  logic [$clog2(MAX_GROUP)-1:0]        raddr,
  output logic                                rd_free,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sgr_pkg::VALUE_W-1:0]  out_value,
  output logic                                out_last
);
  import sgr_pkg::*;

  logic signed [VALUE_W-1:0] mem_r [MAX_GROUP];
  logic signed [VALUE_W-1:0] rdata_r;
  logic                      rd_vld_r, rd_vld_nxt;
  logic                      rd_last_r;
  logic                      out_vld_r, out_vld_nxt;
  logic signed [VALUE_W-1:0] out_val_r;
  logic                      out_last_r;
  logic                      load;

  always_ff @(posedge clk) begin
    if (ctl.we) mem_r[waddr] <= wdata;
    if (ctl.re) begin
      rdata_r   <= mem_r[raddr];
      rd_last_r <= ctl.rlast;
    end
  end

  // read data moves to the output register once it is free
  assign load    = rd_vld_r && (!out_vld_r || out_ready);
  assign rd_free = !rd_vld_r || load;

  always_comb begin
    rd_vld_nxt = rd_vld_r;
    if (ctl.re)    rd_vld_nxt = 1'b1;
    else if (load) rd_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (load)           out_vld_nxt = 1'b1;
    else if (out_ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_val_r  <= rdata_r;
      out_last_r <= rd_last_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_value = out_val_r;
  assign out_last  = out_last_r;

endmodule

FILE: sv/stream_group_reverser.sv
// ----------------------------------------------------------------------------
// stream_group_reverser
// Reverses a stream of signed 32-bit values in groups of group_size.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : valid/ready sink, one value per transaction, last_item marks
//            the final value of a sequence.
//   out_if : valid/ready source, reordered values, result_last set on the
//            final result of a sequence.
//   cfg_*  : group_size write (cfg_we, cfg_wdata); change only while idle.
// Values are written into a MAX_GROUP-deep buffer memory. When a group fills
// (or the sequence ends) the sequencer stops taking input and reads the group
// back, newest first for a full group, arrival order for a short tail.
// Once a group closes the sequencer drains it: each read lands in the read
// data register, then in the output register. Drain issues one memory read
// per cycle while the read register is free; the single read port of the
// buffer sets that rate; group_size 0 or 1 passes values through unchanged.
// A receiver stall holds the output register; the drain pauses behind it and
// input stays blocked until the group is fully read.
// Reset: group_size returns to 3, buffer empties, no results pending.
// ----------------------------------------------------------------------------
module stream_group_reverser #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sgr_in_if.sink                            in_if,
  sgr_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [sgr_pkg::GROUP_SIZE_W-1:0]  cfg_wdata
);
  import sgr_pkg::*;

  localparam int AW = $clog2(MAX_GROUP);

  logic [GROUP_SIZE_W-1:0] group_size_r;
  sgr_mem_ctl_t            ctl;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           raddr;
  logic                    rd_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GROUP_SIZE_RST;
    end else if (cfg_we) begin
      group_size_r <= cfg_wdata;
    end
  end

  // fill/drain control
  sgr_seq #(.MAX_GROUP(MAX_GROUP)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_last    (in_if.last_item),
    .in_ready   (in_if.ready),
    .group_size (group_size_r),
    .rd_free    (rd_free),
    .ctl        (ctl),
    .waddr      (waddr),
    .raddr      (raddr)
  );

  // buffer memory and output register
  sgr_mem #(.MAX_GROUP(MAX_GROUP)) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .waddr     (waddr),
    .wdata     (in_if.value),
    .raddr     (raddr),
    .rd_free   (rd_free),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_value (out_if.result_value),
    .out_last  (out_if.result_last)
  );

endmodule

FILE: sv/sgr_chk.sv
// ----------------------------------------------------------------------------
// sgr_chk
// Port-level assertions for the stream group reverser.
// ----------------------------------------------------------------------------
module sgr_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sgr_pkg::VALUE_W-1:0]       out_value,
  input logic                              out_last,
  input logic                              cfg_we,
  input logic [sgr_pkg::GROUP_SIZE_W-1:0]  cfg_wdata
);
  import sgr_pkg::*;

  logic [GROUP_SIZE_W-1:0] gs_r;

  // shadow of the group size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r <= GROUP_SIZE_RST;
    end else if (cfg_we) begin
      gs_r <= cfg_wdata;
    end
  end

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after end of sequence");

  a_pass_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && gs_r <= GROUP_SIZE_W'(1) |=> !in_ready)
    else $error("pass-through value not drained");

endmodule

bind stream_group_reverser sgr_chk u_sgr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_last   (in_if.last_item),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_value (out_if.result_value),
  .out_last  (out_if.result_last),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata)
);
